// ===== rtl/core/heb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heb_pkg
// Shared widths, codes and reset values for the hourly energy bar graph core.
// ----------------------------------------------------------------------------
package heb_pkg;

  localparam int unsigned NUM_BARS_DEF = 24;

  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned READING_W = 30;
  localparam int unsigned ENTRY_W   = 16;
  localparam int unsigned VALUE_W   = 7;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned TOTAL_W   = 21;
  localparam int unsigned PROD_W    = ENTRY_W + VALUE_W;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ENTRY_W-1:0] MAX_WH_RST     = 16'd50000;
  localparam logic [VALUE_W-1:0] BAR_HEIGHT_RST = 7'd64;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = 21'h1FFFFF;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_GRAPH = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_WH = 1'b0,
    CFG_BAR_H  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/heb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module heb_ram #(
  parameter int unsigned WIDTH = heb_pkg::ENTRY_W,
  parameter int unsigned DEPTH = heb_pkg::NUM_BARS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/heb_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heb_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// VALUE_W bits (dividend < divisor << VALUE_W).
// ----------------------------------------------------------------------------
module heb_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [heb_pkg::PROD_W-1:0]    dividend_i,
  input  wire logic [heb_pkg::ENTRY_W-1:0]   divisor_i,
  output heb_pkg::div_stat_t                 stat_o,
  output logic      [heb_pkg::VALUE_W-1:0]   quot_o
);

  localparam int unsigned EW = heb_pkg::ENTRY_W;
  localparam int unsigned QW = heb_pkg::VALUE_W;
  localparam int unsigned CW = $clog2(QW);

  logic [EW-1:0] rem_q, rem_d;
  logic [QW-1:0] low_q, low_d;
  logic [EW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [EW:0]   trial;
  logic [EW:0]   diff;
  logic          qbit;

  always_comb begin
    trial = {rem_q, low_q[QW-1]};
    diff  = trial - {1'b0, div_q};
    qbit  = (trial >= {1'b0, div_q});
    rem_d = qbit ? diff[EW-1:0] : trial[EW-1:0];
    low_d = {low_q[QW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[heb_pkg::PROD_W-1:QW];
      low_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = low_q;

endmodule

`default_nettype wire

// ===== rtl/core/hourly_energy_history_bars_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hourly_energy_history_bars_core
// Hourly energy history with bar graph readout.
// ----------------------------------------------------------------------------
// Store items (tuser 0) with a nonzero reading update the current-hour entry.
// A graph item (tuser 1) emits NUM_BARS items, oldest bar first. It first
// scans the history RAM once for peak and total, then for each bar does one
// RAM read, one multiply by the bar height and a bit-serial divide by the
// peak. No new item is accepted until the last bar of a graph item has been
// loaded into the output register. The history lives in a ring buffer;
// entries never written read as zero through per-entry valid flags, so no
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module hourly_energy_history_bars_core #(
  parameter int unsigned NUM_BARS = heb_pkg::NUM_BARS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [heb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [heb_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [4:0] hour, [34:5] reading
  input  wire logic [heb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] opcode
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [4:0] bar_index, [11:5] bar_value, [27:12] peak_wh, [48:28] total_wh
  output logic      [heb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                     m_axis_tlast
);

  localparam int unsigned AW  = $clog2(NUM_BARS);
  localparam int unsigned XW  = (AW > heb_pkg::IDX_W) ? AW : heb_pkg::IDX_W;
  localparam int unsigned EW  = heb_pkg::ENTRY_W;
  localparam int unsigned RW  = heb_pkg::READING_W;
  localparam int unsigned HW  = heb_pkg::HOUR_W;
  localparam int unsigned VW  = heb_pkg::VALUE_W;
  localparam int unsigned TW  = heb_pkg::TOTAL_W;
  localparam int unsigned PW  = heb_pkg::PROD_W;
  localparam int unsigned OPAD = heb_pkg::OUT_TDATA_W - heb_pkg::IDX_W - VW - EW - TW;
  localparam logic [AW-1:0] LAST = AW'(NUM_BARS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SCANE = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DIVS  = 3'd5;
  localparam logic [2:0] ST_DIVW  = 3'd6;
  localparam logic [2:0] ST_PUSH  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [EW-1:0]       max_wh_q;
  logic [VW-1:0]       bar_h_q;
  logic [AW-1:0]       head_q;
  logic [HW-1:0]       prev_hour_q;
  logic                prev_valid_q;
  logic [RW-1:0]       start_q;
  logic [RW-1:0]       last_q;
  logic                new_hour_q;
  logic                ready_q;
  logic [NUM_BARS-1:0] valid_q;

  logic [AW-1:0]       ptr_q;
  logic [AW-1:0]       cnt_q;
  logic                pend_q;
  logic                rd_vld_q;
  logic [EW-1:0]       peak_q;
  logic [TW-1:0]       total_q;
  logic [PW-1:0]       prod_q;

  logic                          out_vld_q;
  logic                          out_last_q;
  logic [heb_pkg::IDX_W-1:0]     out_idx_q;
  logic [VW-1:0]                 out_val_q;
  logic [EW-1:0]                 out_peak_q;
  logic [TW-1:0]                 out_total_q;

  logic                in_acc;
  logic                store_go;
  logic                graph_go;
  logic [HW-1:0]       in_hour;
  logic [RW-1:0]       in_rd;
  logic                hour_chg;
  logic                nh;
  logic [AW-1:0]       head_dec;
  logic [AW-1:0]       head_sel;
  logic [AW-1:0]       ptr_dec;
  logic [RW-1:0]       delta;
  logic                bad;
  logic                st_we;
  logic [EW-1:0]       st_wdata;
  logic                ram_re;
  logic [EW-1:0]       ram_rdata;
  logic [EW-1:0]       entry;
  logic                acc_en;
  logic [TW:0]         sum;
  logic                out_free;
  logic [XW-1:0]       cnt_x;
  logic                div_start;
  heb_pkg::div_stat_t  div_stat;
  logic [VW-1:0]       quot;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_hour  = s_axis_tdata[HW-1:0];
  assign in_rd    = s_axis_tdata[HW+RW-1:HW];
  assign store_go = in_acc && (s_axis_tuser == heb_pkg::OP_STORE) && (in_rd != '0);
  assign graph_go = in_acc && (s_axis_tuser == heb_pkg::OP_GRAPH);

  always_comb begin
    hour_chg = !prev_valid_q || (prev_hour_q != in_hour);
    head_dec = (head_q == '0) ? LAST : head_q - AW'(1);
    head_sel = hour_chg ? head_dec : head_q;
    ptr_dec  = (ptr_q == '0) ? LAST : ptr_q - AW'(1);
    nh       = hour_chg || new_hour_q;
    delta    = in_rd - start_q;
    bad      = (in_rd < last_q) || (in_rd < start_q) || (delta > RW'(max_wh_q));
    st_wdata = (nh || bad) ? '0 : delta[EW-1:0];
    st_we    = store_go && (nh || ready_q);
  end

  assign ram_re = (state_q == ST_SCAN) || (state_q == ST_RD);

  heb_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BARS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (head_sel),
    .wdata_i (st_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign entry  = rd_vld_q ? ram_rdata : '0;
  assign acc_en = ((state_q == ST_SCAN) && pend_q) || (state_q == ST_SCANE);
  assign sum    = {1'b0, total_q} + (TW + 1)'(entry);

  assign div_start = (state_q == ST_DIVS);

  heb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (peak_q),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  assign out_free = !out_vld_q || m_axis_tready;
  assign cnt_x    = XW'(cnt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (graph_go) state_d = ST_SCAN;
      ST_SCAN:  if (ptr_q == LAST) state_d = ST_SCANE;
      ST_SCANE: state_d = ST_RD;
      ST_RD:    state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIVS;
      ST_DIVS:  state_d = ST_DIVW;
      ST_DIVW:  if (div_stat.done) state_d = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          state_d = (cnt_q == LAST) ? ST_IDLE : ST_RD;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      max_wh_q     <= heb_pkg::MAX_WH_RST;
      bar_h_q      <= heb_pkg::BAR_HEIGHT_RST;
      head_q       <= '0;
      prev_hour_q  <= '0;
      prev_valid_q <= 1'b0;
      start_q      <= '0;
      last_q       <= '0;
      new_hour_q   <= 1'b1;
      ready_q      <= 1'b0;
      valid_q      <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      rd_vld_q     <= 1'b0;
      peak_q       <= EW'(1);
      total_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          heb_pkg::CFG_MAX_WH: max_wh_q <= cfg_wdata_i;
          heb_pkg::CFG_BAR_H:  bar_h_q  <= cfg_wdata_i[VW-1:0];
          default: ;
        endcase
      end

      if (store_go) begin
        if (hour_chg) begin
          head_q       <= head_dec;
          prev_hour_q  <= in_hour;
          prev_valid_q <= 1'b1;
        end
        if (nh) begin
          new_hour_q <= 1'b0;
          ready_q    <= 1'b1;
          start_q    <= in_rd;
          last_q     <= in_rd;
        end else if (ready_q) begin
          if (bad) begin
            start_q <= in_rd;
          end
          last_q <= in_rd;
        end
      end
      if (st_we) begin
        valid_q[head_sel] <= 1'b1;
      end

      if (ram_re) begin
        rd_vld_q <= valid_q[ptr_q];
      end

      if (graph_go) begin
        ptr_q   <= '0;
        pend_q  <= 1'b0;
        peak_q  <= EW'(1);
        total_q <= '0;
      end
      if (state_q == ST_SCAN) begin
        pend_q <= 1'b1;
        ptr_q  <= ptr_q + AW'(1);
      end
      if (acc_en) begin
        if (entry > peak_q) begin
          peak_q <= entry;
        end
        total_q <= (sum > (TW + 1)'(heb_pkg::TOTAL_MAX)) ? heb_pkg::TOTAL_MAX : sum[TW-1:0];
      end
      if (state_q == ST_SCANE) begin
        ptr_q <= head_dec;
        cnt_q <= '0;
      end
      if ((state_q == ST_PUSH) && out_free) begin
        ptr_q <= ptr_dec;
        cnt_q <= cnt_q + AW'(1);
      end

      if ((state_q == ST_PUSH) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= PW'(entry) * PW'(bar_h_q);
    end
    if ((state_q == ST_PUSH) && out_free) begin
      out_idx_q   <= cnt_x[heb_pkg::IDX_W-1:0];
      out_val_q   <= quot;
      out_peak_q  <= peak_q;
      out_total_q <= ready_q ? total_q : '0;
      out_last_q  <= (cnt_q == LAST);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{OPAD{1'b0}}, out_total_q, out_peak_q, out_val_q, out_idx_q};

`ifndef NO_ASSERTIONS
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_stat.busy)
    else $error("divider busy while accepting items");

  a_peak_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> (peak_q != '0))
    else $error("peak is zero during readout");

  a_quot_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (quot <= bar_h_q))
    else $error("bar value above full scale");

  a_first_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !prev_valid_q |-> (new_hour_q && !ready_q))
    else $error("history ready before any hour seen");

  a_push_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PUSH) && !out_free) |=> (state_q == ST_PUSH))
    else $error("bar dropped while output stalled");
`endif

endmodule

`default_nettype wire

// ===== verif/hourly_energy_history_bars_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hourly_energy_history_bars_core_tb
// Self-checking bench for the hourly energy history bar graph core.
// ----------------------------------------------------------------------------
// A directed table runs first: graph requests right after reset, zero
// readings, first reading, backward steps, spikes, the spike limit itself,
// out-of-range hours and the largest reading. Random meter traffic follows:
// mostly rising readings within an hour with occasional hour changes, plus
// spikes, backward steps, zero readings and noise. The traffic runs under
// several register settings, the extremes among them. Each graph request is
// predicted bar by bar and every output item is checked in order. Both sides
// idle in random bursts but for the last phase, and one long sink stall backs up the input.
// ----------------------------------------------------------------------------
module hourly_energy_history_bars_core_tb;
  import heb_pkg::*;

  localparam int unsigned BARS           = NUM_BARS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 32;
  localparam int unsigned RAND_PER_PHASE = 52;
  localparam int unsigned NUM_PHASES     = 7;
  localparam int unsigned MAX_READING    = 999999999;
  localparam int unsigned DIR_N          = 21;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
    logic [ENTRY_W-1:0] peak;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } bar_t;

  typedef struct packed {
    opcode_e              op;
    logic [HOUR_W-1:0]    hour;
    logic [READING_W-1:0] reading;
    logic                 typed;
    logic [VALUE_W-1:0]   t_value;
    logic [ENTRY_W-1:0]   t_peak;
    logic [TOTAL_W-1:0]   t_total;
  } dir_row_t;

  // typed rows: every bar carries the same value, peak and total
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{OP_GRAPH, 5'd0,  30'd0,         1'b1, 7'd0, 16'd1, 21'd0},
    '{OP_STORE, 5'd0,  30'd0,         1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_GRAPH, 5'd0,  30'd0,         1'b1, 7'd0, 16'd1, 21'd0},
    '{OP_STORE, 5'd0,  30'd1000,      1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_GRAPH, 5'd31, 30'h3FFFFFFF,  1'b1, 7'd0, 16'd1, 21'd0},
    '{OP_STORE, 5'd0,  30'd1500,      1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd0,  30'd51000,     1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_GRAPH, 5'd0,  30'd0,         1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd0,  30'd51001,     1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd0,  30'd60000,     1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd0,  30'd59000,     1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd0,  30'd59100,     1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd1,  30'd59200,     1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd1,  30'd124735,    1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd1,  30'd100000,    1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd31, 30'd100100,    1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd31, 30'd999999999, 1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_GRAPH, 5'd23, 30'd12345,     1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd23, 30'd999999999, 1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_STORE, 5'd23, 30'd999999999, 1'b0, 7'd0, 16'd0, 21'd0},
    '{OP_GRAPH, 5'd0,  30'd0,         1'b0, 7'd0, 16'd0, 21'd0}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_MAX_WH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  hourly_energy_history_bars_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirror of the history and meter state
  logic [ENTRY_W-1:0]   hist [BARS];
  logic [HOUR_W-1:0]    cur_hour;
  bit                   hour_seen;
  logic [READING_W-1:0] hour_base;
  logic [READING_W-1:0] last_rd;
  bit                   hour_fresh;
  bit                   hist_ready;
  logic [ENTRY_W-1:0]   spike_limit;
  logic [VALUE_W-1:0]   full_height;

  bar_t        bar_exp_q [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned gen_meter = 1000;
  logic [HOUR_W-1:0] gen_hour = '0;

  function automatic void meter_resync(logic [READING_W-1:0] rd);
    hour_base = rd;
    last_rd   = rd;
    hist[0]   = '0;
  endfunction

  function automatic void meter_store(logic [HOUR_W-1:0] hr, logic [READING_W-1:0] rd);
    int unsigned delta;
    int k;
    if (rd == 0) return;
    if (!hour_seen || cur_hour != hr) begin
      for (k = BARS - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0]    = '0;
      hour_fresh = 1'b1;
      cur_hour   = hr;
      hour_seen  = 1'b1;
    end
    if (hour_fresh) begin
      hour_fresh = 1'b0;
      hist_ready = 1'b1;
      meter_resync(rd);
      return;
    end
    if (!hist_ready) return;
    if (rd < last_rd || rd < hour_base) begin
      meter_resync(rd);
      return;
    end
    delta = 32'(rd) - 32'(hour_base);
    if (delta > 32'(spike_limit)) begin
      meter_resync(rd);
      return;
    end
    hist[0] = delta[ENTRY_W-1:0];
    last_rd = rd;
  endfunction

  function automatic void graph_predict();
    int unsigned pk, tot, v;
    int k;
    bar_t b;
    pk  = 1;
    tot = 0;
    for (k = 0; k < BARS; k++) begin
      if (32'(hist[k]) > pk) pk = 32'(hist[k]);
      tot += 32'(hist[k]);
      if (tot > 32'(TOTAL_MAX)) tot = 32'(TOTAL_MAX);
    end
    if (!hist_ready) tot = 0;
    for (k = 0; k < BARS; k++) begin
      v       = (32'(hist[BARS-1-k]) * 32'(full_height)) / pk;
      b.idx   = k[IDX_W-1:0];
      b.value = v[VALUE_W-1:0];
      b.peak  = pk[ENTRY_W-1:0];
      b.total = tot[TOTAL_W-1:0];
      b.last  = (k == BARS - 1);
      bar_exp_q.push_back(b);
    end
  endfunction

  task automatic send_item(opcode_e op, logic [HOUR_W-1:0] hr, logic [READING_W-1:0] rd,
                           logic typed, logic [VALUE_W-1:0] t_value,
                           logic [ENTRY_W-1:0] t_peak, logic [TOTAL_W-1:0] t_total);
    int gap;
    int k;
    bar_t b;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_TDATA_W - HOUR_W - READING_W){1'b0}}, rd, hr};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_STORE) begin
      meter_store(hr, rd);
    end else if (typed) begin
      for (k = 0; k < BARS; k++) begin
        b = '{idx: k[IDX_W-1:0], value: t_value, peak: t_peak, total: t_total,
              last: (k == BARS - 1)};
        bar_exp_q.push_back(b);
      end
    end else begin
      graph_predict();
    end
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (bar_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic [ENTRY_W-1:0] max_wh, logic [VALUE_W-1:0] height);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MAX_WH;
    cfg_wdata_i <= max_wh;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BAR_H;
    cfg_wdata_i <= {9'($urandom_range(0, 511)), height};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    spike_limit = max_wh;
    full_height = height;
  endtask

  task automatic pick_meter_item(output opcode_e op, output logic [HOUR_W-1:0] hr,
                                 output logic [READING_W-1:0] rd);
    int unsigned r, mx, nxt, back;
    r   = $urandom_range(0, 99);
    mx  = (spike_limit == 0) ? 1 : 32'(spike_limit);
    op  = OP_STORE;
    hr  = gen_hour;
    nxt = gen_meter;
    if (r < 18) begin
      op  = OP_GRAPH;
      hr  = $urandom_range(0, 31);
      nxt = $urandom_range(0, MAX_READING);
    end else if (r < 21) begin
      nxt = 0;
    end else if (r < 24) begin
      hr  = $urandom_range(0, 31);
      nxt = $urandom_range(1, MAX_READING);
    end else if (r < 29) begin
      back = (gen_meter - 1 < 5000) ? gen_meter - 1 : 5000;
      nxt  = (gen_meter > 1) ? gen_meter - $urandom_range(1, back) : 0;
    end else if (r < 34) begin
      nxt = gen_meter + mx + 1 + $urandom_range(0, 1000);
    end else begin
      if (r < 37) begin
        gen_hour = $urandom_range(0, 31);
      end else if ($urandom_range(0, 99) < 15) begin
        gen_hour = HOUR_W'((32'(gen_hour) + 1) % 24);
      end
      hr  = gen_hour;
      nxt = gen_meter + $urandom_range(0, mx / 4 + 1);
    end
    if (nxt > MAX_READING) nxt = MAX_READING;
    rd = nxt[READING_W-1:0];
    if (op == OP_STORE && nxt != 0) begin
      gen_meter = (nxt > 990000000) ? $urandom_range(1, 1000) : nxt;
    end
  endtask

  // sink side: random stalls, one long hold on request
  initial begin
    int n;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 15);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : bar_check
    bar_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{idx: m_axis_tdata[4:0], value: m_axis_tdata[11:5], peak: m_axis_tdata[27:12],
              total: m_axis_tdata[48:28], last: m_axis_tlast};
      if (bar_exp_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected bar item: idx %0d value %0d peak %0d total %0d last %0d",
                   got.idx, got.value, got.peak, got.total, got.last);
        mismatches++;
      end else begin
        want = bar_exp_q.pop_front();
        if (got.idx !== want.idx || got.value !== want.value || got.peak !== want.peak ||
            got.total !== want.total || got.last !== want.last) begin
          if (mismatches < 10)
            $display("bar mismatch: exp idx %0d value %0d peak %0d total %0d last %0d, got idx %0d value %0d peak %0d total %0d last %0d",
                     want.idx, want.value, want.peak, want.total, want.last,
                     got.idx, got.value, got.peak, got.total, got.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int ph, i;
    opcode_e op;
    logic [HOUR_W-1:0] hr;
    logic [READING_W-1:0] rd;
    logic [ENTRY_W-1:0] cmax;
    logic [VALUE_W-1:0] chgt;

    for (i = 0; i < BARS; i++) hist[i] = '0;
    cur_hour    = '0;
    hour_seen   = 1'b0;
    hour_base   = '0;
    last_rd     = '0;
    hour_fresh  = 1'b1;
    hist_ready  = 1'b0;
    spike_limit = MAX_WH_RST;
    full_height = BAR_HEIGHT_RST;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_N; i++)
      send_item(DIR_TAB[i].op, DIR_TAB[i].hour, DIR_TAB[i].reading, DIR_TAB[i].typed,
                DIR_TAB[i].t_value, DIR_TAB[i].t_peak, DIR_TAB[i].t_total);

    // back-to-back graph requests against a held sink
    hold_req = 1'b1;
    repeat (8)
      send_item(OP_GRAPH, HOUR_W'($urandom_range(0, 31)),
                READING_W'($urandom_range(0, MAX_READING)), 1'b0, '0, '0, '0);
    drain_and_settle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin cmax = 16'd65535; chgt = 7'd127; end
        1: begin cmax = 16'd1;     chgt = 7'd1;   end
        2: begin cmax = 16'd0;     chgt = 7'd0;   end
        5: begin cmax = 16'd65535; chgt = 7'd1;   end
        6: begin cmax = MAX_WH_RST; chgt = BAR_HEIGHT_RST; end
        default: begin
          cmax = $urandom_range(1, 65535);
          chgt = $urandom_range(1, 127);
        end
      endcase
      write_config(cmax, chgt);
      if (ph == NUM_PHASES - 1) idle_en = 1'b0;
      repeat (RAND_PER_PHASE) begin
        pick_meter_item(op, hr, rd);
        send_item(op, hr, rd, 1'b0, '0, '0, '0);
      end
      drain_and_settle();
    end

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
